// File: rtl/owm_pkg.sv
package owm_pkg;

    localparam int CFG_COUNT    = 8;
    localparam int CFG_WIDTH    = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int QUEUE_DEPTH  = 2;

    // command kinds as they arrive on the input channel
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 3'd7;

    localparam logic [CFG_WIDTH-1:0] CFG_DEFAULT [CFG_COUNT] = '{
        16'd1000, 16'd60, 16'd1000, 16'd15, 16'd62, 16'd65, 16'd5, 16'd70
    };

    localparam logic [CFG_WIDTH-1:0] RD_LOW_TICKS  = 16'd5;
    localparam logic [CFG_WIDTH-1:0] RD_WAIT_TICKS = 16'd5;

    typedef struct packed {
        logic       is_tick;
        logic [1:0] kind;
        logic [7:0] byte_val;
        logic       level;
    } cmd_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       rejected;
        logic       presence;
        logic [7:0] byte_out;
    } res_t;

endpackage

// File: rtl/owm_if.sv
interface owm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_in;
    logic       line_level;

    modport source (output valid, output kind, output byte_in, output line_level,
                    input ready);
    modport sink (input valid, input kind, input byte_in, input line_level,
                  output ready);
endinterface

interface owm_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       rejected;
    logic       presence;
    logic [7:0] byte_out;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output rejected, output presence, output byte_out, input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input rejected, input presence, input byte_out, output ready);
endinterface

// File: rtl/owm_front.sv
module owm_front
    import owm_pkg::*;
(
    owm_in_if.sink in_ch,
    input  logic   full,
    output logic   push,
    output cmd_t   cmd
);

    assign in_ch.ready = !full;
    assign push        = in_ch.valid && !full;

    // classify the beat: a tick spends time, anything else is a command
    always_comb
    begin
        cmd.is_tick  = (in_ch.kind == KIND_TICK);
        cmd.kind     = in_ch.kind;
        cmd.byte_val = (in_ch.kind == KIND_WRITE) ? in_ch.byte_in : 8'd0;
        cmd.level    = in_ch.line_level;
    end

endmodule

// File: rtl/owm_queue.sv
module owm_queue
    import owm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic valid,
    output logic full,
    output cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign valid = (count_reg != '0);
    assign full  = (count_reg == FULL_CNT);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/owm_back.sv
module owm_back
    import owm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  cmd_t                 q_head,
    output logic                 pop,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    owm_out_if.source            out_ch
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_W_LOW    = 4'd4;
    localparam logic [3:0] PH_W_HIGH   = 4'd5;
    localparam logic [3:0] PH_R_LOW    = 4'd6;
    localparam logic [3:0] PH_R_WAIT   = 4'd7;
    localparam logic [3:0] PH_R_TAIL   = 4'd8;

    logic [CFG_WIDTH-1:0] cfg_reg [CFG_COUNT];

    logic [3:0]           phase_reg,  phase_next;
    logic [CFG_WIDTH-1:0] count_reg,  count_next;
    logic [2:0]           bit_reg,    bit_next;
    logic [7:0]           shift_reg,  shift_next;
    logic                 pres_reg,   pres_next;
    logic [1:0]           op_reg,     op_next;
    logic                 out_valid_reg;
    res_t                 res_reg,    res_next;

    logic                 busy;
    logic                 done;
    logic                 rej;
    logic [2:0]           bit_inc;

    // take the next beat whenever the output register is free or draining
    assign pop     = q_valid && (!out_valid_reg || out_ch.ready);
    assign busy    = (phase_reg != PH_IDLE);
    assign bit_inc = bit_reg + 3'd1;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        pres_next  = pres_reg;
        op_next    = op_reg;
        done       = 1'b0;
        rej        = 1'b0;
        if (q_head.is_tick)
        begin
            if (busy)
            begin
                if (count_reg > 16'd1)
                begin
                    count_next = count_reg - 16'd1;
                end
                else
                begin
                    case (phase_reg)
                        PH_RST_LOW:
                        begin
                            phase_next = PH_RST_WAIT;
                            count_next = cfg_reg[REG_PRESENCE_WAIT];
                        end
                        PH_RST_WAIT:
                        begin
                            pres_next  = !q_head.level;
                            phase_next = PH_RST_TAIL;
                            count_next = cfg_reg[REG_RESET_TAIL];
                        end
                        PH_W_LOW:
                        begin
                            phase_next = PH_W_HIGH;
                            count_next = shift_reg[bit_reg] ? cfg_reg[REG_ONE_HIGH]
                                                            : cfg_reg[REG_ZERO_HIGH];
                        end
                        PH_W_HIGH:
                        begin
                            if (bit_reg == 3'd7)
                            begin
                                phase_next = PH_IDLE;
                                count_next = '0;
                                done       = 1'b1;
                            end
                            else
                            begin
                                bit_next   = bit_inc;
                                phase_next = PH_W_LOW;
                                count_next = shift_reg[bit_inc] ? cfg_reg[REG_ONE_LOW]
                                                                : cfg_reg[REG_ZERO_LOW];
                            end
                        end
                        PH_R_LOW:
                        begin
                            phase_next = PH_R_WAIT;
                            count_next = RD_WAIT_TICKS;
                        end
                        PH_R_WAIT:
                        begin
                            if (q_head.level)
                            begin
                                shift_next[bit_reg] = 1'b1;
                            end
                            phase_next = PH_R_TAIL;
                            count_next = cfg_reg[REG_READ_TAIL];
                        end
                        PH_R_TAIL:
                        begin
                            if (bit_reg == 3'd7)
                            begin
                                phase_next = PH_IDLE;
                                count_next = '0;
                                done       = 1'b1;
                            end
                            else
                            begin
                                bit_next   = bit_inc;
                                phase_next = PH_R_LOW;
                                count_next = RD_LOW_TICKS;
                            end
                        end
                        PH_RST_TAIL:
                        begin
                            phase_next = PH_IDLE;
                            count_next = '0;
                            done       = 1'b1;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            count_next = '0;
                        end
                    endcase
                end
            end
        end
        else if (busy)
        begin
            rej = 1'b1;
        end
        else
        begin
            op_next  = q_head.kind;
            bit_next = 3'd0;
            case (q_head.kind)
                KIND_RESET:
                begin
                    phase_next = PH_RST_LOW;
                    count_next = cfg_reg[REG_RESET_LOW];
                end
                KIND_WRITE:
                begin
                    shift_next = q_head.byte_val;
                    phase_next = PH_W_LOW;
                    count_next = q_head.byte_val[0] ? cfg_reg[REG_ONE_LOW]
                                                    : cfg_reg[REG_ZERO_LOW];
                end
                default:
                begin
                    shift_next = 8'd0;
                    phase_next = PH_R_LOW;
                    count_next = RD_LOW_TICKS;
                end
            endcase
        end

        res_next.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_W_LOW)
                             || (phase_next == PH_R_LOW);
        res_next.busy_res  = (phase_next != PH_IDLE);
        res_next.done_res  = done;
        res_next.rejected  = rej;
        res_next.presence  = pres_next;
        res_next.byte_out  = (op_next == KIND_READ) ? shift_next : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            pres_reg      <= 1'b0;
            op_reg        <= KIND_TICK;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                cfg_reg[i] <= CFG_DEFAULT[i];
            end
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                pres_reg  <= pres_next;
                op_reg    <= op_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.drive_low = res_reg.drive_low;
    assign out_ch.busy_res  = res_reg.busy_res;
    assign out_ch.done_res  = res_reg.done_res;
    assign out_ch.rejected  = res_reg.rejected;
    assign out_ch.presence  = res_reg.presence;
    assign out_ch.byte_out  = res_reg.byte_out;

`ifndef SYNTH
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.done_res |-> !res_reg.busy_res)
        else $error("command finished but still busy");

    a_reject_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.rejected |-> res_reg.busy_res && !res_reg.done_res)
        else $error("rejected command while idle");

    a_drive_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.drive_low |-> res_reg.busy_res)
        else $error("bus pulled low while idle");

    a_bit_index_reset: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !q_head.is_tick && !busy |=> bit_reg == 3'd0)
        else $error("bit index not cleared on new command");
`endif

endmodule

// File: rtl/one_wire_bus_master.sv
// A result passes through the command queue and then the output register after its beat is accepted.
// Throughput: one beat per cycle while out_ch is ready; the command queue and output register decouple stalls.
// Each tick and command is a single update of the phase counter in the back end.
// Reset (rst_n, asynchronous, active low) empties the queue, idles the bus sequencer
// and returns every timing register to its default value.
module one_wire_bus_master
    import owm_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    owm_in_if.sink               in_ch,
    owm_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data
);

    logic push;
    logic full;
    logic q_valid;
    logic pop;
    cmd_t push_cmd;
    cmd_t q_head;

    owm_front u_front (
        .in_ch (in_ch),
        .full  (full),
        .push  (push),
        .cmd   (push_cmd)
    );

    owm_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .valid    (q_valid),
        .full     (full),
        .head     (q_head)
    );

    owm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ch    (out_ch)
    );

endmodule
